/* src/refcounted_lru_cache_shard_defines.svh */
// assertion helpers for the cache shard
`ifndef REFCOUNTED_LRU_CACHE_SHARD_DEFINES_SVH
`define REFCOUNTED_LRU_CACHE_SHARD_DEFINES_SVH
`ifndef SYNTHESIS
`define RLC_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RLC_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define RLC_ASSERT_IMP(lbl, a, c)
`define RLC_ASSERT_NXT(lbl, a, c)
`endif
`endif

/* src/rlc_pkg.sv */
package rlc_pkg;
    localparam int ENTRY_SLOTS = 32;
    localparam int KEY_BITS    = 64;
    localparam int SLOT_W      = $clog2(ENTRY_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;

    localparam logic [2:0] OP_LOOKUP        = 3'd0;
    localparam logic [2:0] OP_INSERT        = 3'd1;
    localparam logic [2:0] OP_LOOKUP_INSERT = 3'd2;
    localparam logic [2:0] OP_LOOKUP_ERASE  = 3'd3;
    localparam logic [2:0] OP_ERASE         = 3'd4;
    localparam logic [2:0] OP_RELEASE       = 3'd5;
    localparam logic [2:0] OP_PRUNE         = 3'd6;
    localparam logic [2:0] OP_UNUSED        = 3'd7;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_NO_FREE   = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    localparam logic KIND_FINAL = 1'b0;
    localparam logic KIND_EVICT = 1'b1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] page_key;
        logic [31:0] key_hash;
        logic [15:0] charge;
        logic [4:0]  handle;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [63:0] evicted_key;
        logic [24:0] usage_now;
        logic        last;
    } out_word_t;
endpackage

/* src/refcounted_lru_cache_shard.sv */
// Reference-counted LRU cache shard.
// in_valid/in_ready carry one request word (operation, key, hash, charge,
// handle). out_valid/out_ready carry result words: zero or more eviction
// reports (kind 1) followed by one final answer with last set.
// cfg_valid/cfg_ready writes the capacity register; cfg_ready is always high.
// One request is worked at a time; in_ready is high only when idle. A result
// sits in the output register, so a new request may be taken while the final
// answer of the previous one still waits for out_ready.
// Every key search reads the slot memory once per slot. Lookups, erases and
// inserts each start with one search; a release needs none. Each eviction adds
// another slot-memory sweep, and a prune ends with one more sweep that finds
// nothing. The sweep through the single slot-memory read port sets the rate.
// Reset clears pin counts, in-cache marks, age counter, usage and capacity;
// key, charge and age storage need no clearing. A stalled receiver holds the
// block in its current step with no state change until the word is taken.
module refcounted_lru_cache_shard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rlc_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rlc_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);
    import rlc_pkg::*;

    `include "refcounted_lru_cache_shard_defines.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_EVICT = 3'd4;
    localparam logic [2:0] S_REL   = 3'd5;
    localparam logic [2:0] S_NOP   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [7:0] pins_reg [ENTRY_SLOTS];
    logic [7:0] pins_next [ENTRY_SLOTS];
    logic [ENTRY_SLOTS-1:0] cached_reg, cached_next;
    logic [31:0] age_ctr_reg, age_ctr_next;
    logic [24:0] usage_reg, usage_next;
    logic [23:0] cap_reg;
    in_word_t    req_reg, req_next;

    logic             lru_mode_reg, lru_mode_next;
    logic             prune_reg, prune_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             found_vld_reg, found_vld_next;
    logic [SLOT_W-1:0] found_idx_reg, found_idx_next;
    logic [15:0]      found_chg_reg, found_chg_next;
    logic             best_vld_reg, best_vld_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]      best_d_reg, best_d_next;
    logic [KEY_BITS-1:0] best_key_reg, best_key_next;
    logic [15:0]      best_chg_reg, best_chg_next;
    logic [2:0]       fin_status_reg, fin_status_next;
    logic [SLOT_W-1:0] fin_slot_reg, fin_slot_next;

    logic out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;
    logic load;
    logic out_free;

    // slot memory
    logic [KEY_BITS-1:0] key_mem [ENTRY_SLOTS];
    logic [15:0]         chg_mem [ENTRY_SLOTS];
    logic [31:0]         age_mem [ENTRY_SLOTS];
    logic [SLOT_W-1:0]   rd_addr;
    logic [KEY_BITS-1:0] rd_key;
    logic [15:0]         rd_chg;
    logic [31:0]         rd_age;
    logic [SLOT_W-1:0]   rd_idx_reg;
    logic                rd_vld_reg, rd_vld_next;
    logic                ent_we, age_we;
    logic [SLOT_W-1:0]   ent_waddr, age_waddr;
    logic [31:0]         age_wdata;

    logic                free_vld;
    logic [SLOT_W-1:0]   free_idx;
    logic [31:0]         scan_d;
    logic [SLOT_W-1:0]   h;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign rd_addr   = cnt_reg[SLOT_W-1:0];
    assign h         = req_reg.handle[SLOT_W-1:0];
    assign scan_d    = age_ctr_reg - rd_age;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            key_mem[ent_waddr] <= req_reg.page_key[KEY_BITS-1:0];
            chg_mem[ent_waddr] <= req_reg.charge;
        end
        if (age_we)
        begin
            age_mem[age_waddr] <= age_wdata;
        end
        rd_key <= key_mem[rd_addr];
        rd_chg <= chg_mem[rd_addr];
        rd_age <= age_mem[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    // lowest free slot
    always_comb
    begin
        free_vld = 1'b0;
        free_idx = '0;
        for (int i = ENTRY_SLOTS - 1; i >= 0; i--)
        begin
            if (pins_reg[i] == 8'd0)
            begin
                free_vld = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pins_next       = pins_reg;
        cached_next     = cached_reg;
        age_ctr_next    = age_ctr_reg;
        usage_next      = usage_reg;
        req_next        = req_reg;
        lru_mode_next   = lru_mode_reg;
        prune_next      = prune_reg;
        cnt_next        = cnt_reg;
        found_vld_next  = found_vld_reg;
        found_idx_next  = found_idx_reg;
        found_chg_next  = found_chg_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_d_next     = best_d_reg;
        best_key_next   = best_key_reg;
        best_chg_next   = best_chg_reg;
        fin_status_next = fin_status_reg;
        fin_slot_next   = fin_slot_reg;
        rd_vld_next     = 1'b0;
        ent_we          = 1'b0;
        ent_waddr       = free_idx;
        age_we          = 1'b0;
        age_waddr       = h;
        age_wdata       = '0;
        load            = 1'b0;
        out_next        = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next       = in_data;
                    cnt_next       = '0;
                    found_vld_next = 1'b0;
                    best_vld_next  = 1'b0;
                    prune_next     = 1'b0;
                    lru_mode_next  = 1'b0;
                    if (in_data.operation == OP_RELEASE)
                    begin
                        state_next = S_REL;
                    end
                    else if (in_data.operation == OP_PRUNE)
                    begin
                        prune_next      = 1'b1;
                        fin_status_next = ST_DONE;
                        fin_slot_next   = '0;
                        state_next      = S_CHECK;
                    end
                    else if (in_data.operation == OP_UNUSED)
                    begin
                        state_next = S_NOP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != CNT_W'(ENTRY_SLOTS))
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (!lru_mode_reg)
                    begin
                        if (!found_vld_reg && pins_reg[rd_idx_reg] != 8'd0 &&
                            cached_reg[rd_idx_reg] &&
                            rd_key == req_reg.page_key[KEY_BITS-1:0])
                        begin
                            found_vld_next = 1'b1;
                            found_idx_next = rd_idx_reg;
                            found_chg_next = rd_chg;
                        end
                    end
                    else if (cached_reg[rd_idx_reg] && pins_reg[rd_idx_reg] == 8'd1 &&
                             (!best_vld_reg || scan_d > best_d_reg))
                    begin
                        best_vld_next = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_d_next   = scan_d;
                        best_key_next = rd_key;
                        best_chg_next = rd_chg;
                    end
                end
                else if (cnt_reg == CNT_W'(ENTRY_SLOTS))
                begin
                    state_next = lru_mode_reg ? S_EVICT : S_FIND;
                end
            end
            S_FIND:
            begin
                if (out_free)
                begin
                    out_next = '{KIND_FINAL, ST_NOT_FOUND, '0, '0, usage_reg, 1'b1};
                    load = 1'b1;
                    state_next = S_IDLE;
                    case (req_reg.operation) inside
                        OP_LOOKUP, OP_LOOKUP_INSERT:
                        begin
                            if (found_vld_reg)
                            begin
                                if (pins_reg[found_idx_reg] != 8'd255)
                                begin
                                    pins_next[found_idx_reg] = pins_reg[found_idx_reg] + 8'd1;
                                end
                                out_next.status = ST_HIT;
                                out_next.slot   = 5'(found_idx_reg);
                            end
                        end
                        OP_LOOKUP_ERASE:
                        begin
                            if (found_vld_reg)
                            begin
                                cached_next[found_idx_reg] = 1'b0;
                                usage_next = usage_reg - 25'(found_chg_reg);
                                out_next.status    = ST_HIT;
                                out_next.slot      = 5'(found_idx_reg);
                                out_next.usage_now = usage_next;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (found_vld_reg)
                            begin
                                cached_next[found_idx_reg] = 1'b0;
                                usage_next = usage_reg - 25'(found_chg_reg);
                                if (pins_reg[found_idx_reg] != 8'd0)
                                begin
                                    pins_next[found_idx_reg] = pins_reg[found_idx_reg] - 8'd1;
                                end
                                out_next.status    = ST_DONE;
                                out_next.slot      = 5'(found_idx_reg);
                                out_next.usage_now = usage_next;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (req_reg.operation == OP_INSERT ||
                        (req_reg.operation == OP_LOOKUP_INSERT && !found_vld_reg))
                    begin
                        if (!free_vld)
                        begin
                            out_next.status = ST_NO_FREE;
                        end
                        else
                        begin
                            load   = 1'b0;
                            ent_we = 1'b1;
                            age_we = 1'b1;
                            age_waddr = free_idx;
                            pins_next[free_idx]   = 8'd1;
                            cached_next[free_idx] = 1'b0;
                            if (cap_reg != 24'd0)
                            begin
                                pins_next[free_idx]   = 8'd2;
                                cached_next[free_idx] = 1'b1;
                                usage_next = usage_reg + 25'(req_reg.charge);
                                if (found_vld_reg)
                                begin
                                    cached_next[found_idx_reg] = 1'b0;
                                    usage_next = usage_next - 25'(found_chg_reg);
                                    pins_next[found_idx_reg] = pins_reg[found_idx_reg] - 8'd1;
                                end
                            end
                            fin_status_next = ST_INSERTED;
                            fin_slot_next   = free_idx;
                            state_next      = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (prune_reg || usage_reg > 25'(cap_reg))
                begin
                    lru_mode_next = 1'b1;
                    cnt_next      = '0;
                    best_vld_next = 1'b0;
                    state_next    = S_SCAN;
                end
                else if (out_free)
                begin
                    out_next = '{KIND_FINAL, fin_status_reg, 5'(fin_slot_reg), '0,
                                 usage_reg, 1'b1};
                    load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EVICT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (best_vld_reg)
                    begin
                        cached_next[best_idx_reg] = 1'b0;
                        pins_next[best_idx_reg]   = pins_reg[best_idx_reg] - 8'd1;
                        usage_next = usage_reg - 25'(best_chg_reg);
                        out_next = '{KIND_EVICT, ST_DONE, 5'(best_idx_reg),
                                     64'(best_key_reg), usage_next, 1'b0};
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        out_next = '{KIND_FINAL, fin_status_reg, 5'(fin_slot_reg), '0,
                                     usage_reg, 1'b1};
                        state_next = S_IDLE;
                    end
                end
            end
            S_REL:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    state_next = S_IDLE;
                    if (32'(req_reg.handle) >= ENTRY_SLOTS || pins_reg[h] == 8'd0 ||
                        (cached_reg[h] && pins_reg[h] == 8'd1))
                    begin
                        out_next = '{KIND_FINAL, ST_NOT_FOUND, '0, '0, usage_reg, 1'b1};
                    end
                    else
                    begin
                        pins_next[h] = pins_reg[h] - 8'd1;
                        if (cached_reg[h] && pins_reg[h] == 8'd2)
                        begin
                            age_we       = 1'b1;
                            age_wdata    = age_ctr_reg;
                            age_ctr_next = age_ctr_reg + 32'd1;
                        end
                        out_next = '{KIND_FINAL, ST_DONE, req_reg.handle, '0, usage_reg, 1'b1};
                    end
                end
            end
            S_NOP:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    out_next = '{KIND_FINAL, ST_NOT_FOUND, '0, '0, usage_reg, 1'b1};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cached_reg    <= '0;
            age_ctr_reg   <= '0;
            usage_reg     <= '0;
            cap_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            for (int i = 0; i < ENTRY_SLOTS; i++)
            begin
                pins_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pins_reg      <= pins_next;
            cached_reg    <= cached_next;
            age_ctr_reg   <= age_ctr_next;
            usage_reg     <= usage_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        lru_mode_reg   <= lru_mode_next;
        prune_reg      <= prune_next;
        cnt_reg        <= cnt_next;
        found_vld_reg  <= found_vld_next;
        found_idx_reg  <= found_idx_next;
        found_chg_reg  <= found_chg_next;
        best_vld_reg   <= best_vld_next;
        best_idx_reg   <= best_idx_next;
        best_d_reg     <= best_d_next;
        best_key_reg   <= best_key_next;
        best_chg_reg   <= best_chg_next;
        fin_status_reg <= fin_status_next;
        fin_slot_reg   <= fin_slot_next;
        out_reg        <= out_next;
    end

    `RLC_ASSERT_NXT(a_final_to_idle, load && out_next.last, state_reg == S_IDLE)
    `RLC_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
    `RLC_ASSERT_IMP(a_evict_not_last, load && out_next.kind == KIND_EVICT, !out_next.last)
endmodule
